[rtl/deq_pkg.sv]
// shared types and constants for the double-ended queue
package deq_pkg;

  localparam int CMD_W          = 3;
  localparam int VALUE_W        = 32;
  localparam int STATUS_W       = 2;
  localparam int FILL_W         = 5;
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_REAR  = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic push_front;  // every cell takes its front-side neighbor
    logic push_rear;   // the cell just past the rear loads the new word
    logic pop_front;   // every cell takes its rear-side neighbor
  } cell_ctl_t;

endpackage

[rtl/deq_ifs.sv]
// valid/ready channel interfaces for commands and results
interface deq_in_if
  import deq_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

interface deq_out_if
  import deq_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] element;
  logic [STATUS_W-1:0]       status;
  logic [FILL_W-1:0]         fill_count;

  modport source (output valid, element, status, fill_count, input ready);
  modport sink   (input valid, element, status, fill_count, output ready);
endinterface

[rtl/double_ended_queue_core.sv]
// bounded double-ended queue built as a shifting chain of word cells
//
// in_ch carries one command word (command, value); out_ch returns one result
// word (element, status, fill_count) for every accepted command, in order.
// the front of the queue always sits in cell 0; push front and pop front
// shift the whole chain by one cell at once, push rear loads the
// cell just past the rear, and the rear word is picked by an or tree over
// the cell taps selected by the element count.
// the result word is registered and shows on out_ch in the cycle after
// the command is accepted. the queue takes one command per cycle while
// out_ch is not stalled, set by the chain shift and the count register.
// when out_ch is stalled the result word holds; in_ch.ready stays high as long
// as the result register is empty or being drained in the same cycle.
// reset empties the queue (count zero, no result pending); cell contents are
// left as they are and are never read before being written.
module double_ended_queue_core
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  deq_in_if.sink    in_ch,
  deq_out_if.source out_ch
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  cell_ctl_t             ctl;
  logic [CNT_W-1:0]      count;
  logic [DATA_WIDTH-1:0] push_word;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] rear_taps [DEPTH];
  logic [DATA_WIDTH-1:0] rear_data;

  assign push_word = DATA_WIDTH'(in_ch.value);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_word;
    logic [DATA_WIDTH-1:0] next_word;

    if (i == 0) begin : g_first
      assign prev_word = push_word;
    end else begin : g_mid_prev
      assign prev_word = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_word = cell_data[i];
    end else begin : g_mid_next
      assign next_word = cell_data[i+1];
    end

    deq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .IDX        (i)
    ) u_cell (
      .clk         (clk),
      .ctl_i       (ctl),
      .count_i     (count),
      .push_word_i (push_word),
      .prev_i      (prev_word),
      .next_i      (next_word),
      .data_o      (cell_data[i]),
      .rear_tap_o  (rear_taps[i])
    );
  end

  always_comb begin
    rear_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_data = rear_data | rear_taps[i];
    end
  end

  deq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .front_i (cell_data[0]),
    .rear_i  (rear_data),
    .ctl_o   (ctl),
    .count_o (count)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count <= CNT_W'(DEPTH))
    else $error("element count above depth");

  a_fill_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.fill_count == FILL_W'(count))
    else $error("pending fill_count differs from element count");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_FULL) |-> count == CNT_W'(DEPTH))
    else $error("full status while queue not full");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_EMPTY) |->
      (count == '0 && out_ch.element == '0))
    else $error("empty status while queue holds words");

endmodule

[rtl/deq_cell.sv]
// one storage cell of the shifting chain
module deq_cell
  import deq_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int CNT_W      = 5,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl_i,
  input  logic [CNT_W-1:0]      count_i,
  input  logic [DATA_WIDTH-1:0] push_word_i,
  input  logic [DATA_WIDTH-1:0] prev_i,
  input  logic [DATA_WIDTH-1:0] next_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [DATA_WIDTH-1:0] rear_tap_o
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic [DATA_WIDTH-1:0] data_r;
  logic                  is_rear;
  logic                  is_free_slot;

  assign is_rear      = (count_i - CNT_W'(1)) == IDX_C;
  assign is_free_slot = count_i == IDX_C;

  always_ff @(posedge clk) begin
    if (ctl_i.push_front) begin
      data_r <= prev_i;
    end else if (ctl_i.pop_front) begin
      data_r <= next_i;
    end else if (ctl_i.push_rear && is_free_slot) begin
      data_r <= push_word_i;
    end
  end

  assign data_o     = data_r;
  // only the rear cell drives its tap, the rest contribute zero to the or tree
  assign rear_tap_o = is_rear ? data_r : '0;

endmodule

[rtl/deq_ctrl.sv]
// command decode, element count and registered result word
module deq_ctrl
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  deq_in_if.sink                in_ch,
  deq_out_if.source             out_ch,
  input  logic [DATA_WIDTH-1:0] front_i,
  input  logic [DATA_WIDTH-1:0] rear_i,
  output cell_ctl_t             ctl_o,
  output logic [CNT_W-1:0]      count_o
);

  logic [CNT_W-1:0]             count_r, count_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0]    element_r;
  logic [STATUS_W-1:0]          status_r;
  logic [FILL_W-1:0]            fill_r;

  logic                         accept;
  logic                         full;
  logic                         empty;
  cmd_t                         cmd;
  cell_ctl_t                    ctl;
  status_t                      status;
  logic signed [DATA_WIDTH-1:0] elem_word;
  logic [CNT_W-1:0]             count_step;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = count_r == CNT_W'(DEPTH);
  assign empty       = count_r == '0;
  assign cmd         = cmd_t'(in_ch.command);

  always_comb begin
    ctl        = '0;
    status     = ST_OK;
    elem_word  = '0;
    count_step = count_r;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctl.push_front = cmd == CMD_PUSH_FRONT;
          ctl.push_rear  = cmd == CMD_PUSH_REAR;
          count_step     = count_r + CNT_W'(1);
        end
      end
      CMD_POP_FRONT, CMD_PEEK_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          elem_word = front_i;
          if (cmd == CMD_POP_FRONT) begin
            ctl.pop_front = 1'b1;
            count_step    = count_r - CNT_W'(1);
          end
        end
      end
      CMD_POP_REAR, CMD_PEEK_REAR: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          elem_word = rear_i;
          // rear pop leaves the cell alone, the count alone moves the rear
          if (cmd == CMD_POP_REAR) begin
            count_step = count_r - CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign ctl_o         = accept ? ctl : '0;
  assign count_nxt     = accept ? count_step : count_r;
  assign out_valid_nxt = accept || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      element_r <= VALUE_W'(elem_word);
      status_r  <= status;
      fill_r    <= FILL_W'(count_step);
    end
  end

  assign count_o           = count_r;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.element    = element_r;
  assign out_ch.status     = status_r;
  assign out_ch.fill_count = fill_r;

endmodule
